// ===== rtl/spas_pkg.sv =====
// ----------------------------------------------------------------------------
// spas_pkg: shared types and constants
// Payload structures, opcodes, controller states, command/status types and a saturating add.
// ----------------------------------------------------------------------------
package spas_pkg;

   localparam int unsigned DefTableDepth = 64;
   localparam int unsigned CoefWidth     = 32;
   localparam int unsigned ExpWidth      = 16;

   typedef enum logic [1:0] {
      OP_LOAD   = 2'd0,
      OP_APPLY  = 2'd1,
      OP_FINISH = 2'd2,
      OP_NONE   = 2'd3
   } opcode_type;

   typedef struct packed {
      logic [1:0]                  opcode;
      logic signed [CoefWidth-1:0] coefficient;
      logic [ExpWidth-1:0]         exponent;
   } req_type;

   typedef struct packed {
      logic signed [CoefWidth-1:0] coefficient_out;
      logic [ExpWidth-1:0]         exponent_out;
      logic                        last_term;
      logic                        empty_result;
      logic                        table_overflow;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_SEARCH_WAIT,
      ST_UPDATE,
      ST_SORT_SCAN,
      ST_SORT_WAIT,
      ST_SORT_SWAP,
      ST_EMIT_READ,
      ST_EMIT_WAIT,
      ST_EMIT_CHECK,
      ST_EMIT_LAST,
      ST_EMIT_SEND
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic capture;     // latch the request
      logic append;      // append the latched term (negated in apply when subtract mode is set)
      logic idx_clear;   // index counter to zero
      logic idx_inc;     // index counter up by one
      logic read_idx;    // read entry at index
      logic read_pair;   // read entries at index and index+1
      logic update;      // write the merged sum or difference at index
      logic swap;        // swap index and index+1
      logic swapped_clr;
      logic hold_load;   // capture the read nonzero term as pending
      logic send;        // present pending term on output register
      logic send_empty;
      logic send_last;
      logic count_clear;
   } cmd_type;

   typedef struct packed {
      logic match;       // read exponent equals request exponent
      logic idx_end;     // index reached entry count
      logic pair_end;    // index+1 reached entry count
      logic out_of_order;
      logic swapped;
      logic nonzero;     // read coefficient is nonzero
      logic have_pending;
      logic rsp_busy;
   } status_type;

   function automatic logic signed [CoefWidth-1:0] sat_add(
      input logic signed [CoefWidth-1:0] a,
      input logic signed [CoefWidth-1:0] b,
      input logic                        sub);
      logic signed [CoefWidth:0] s;
      s = sub ? ({a[CoefWidth-1], a} - {b[CoefWidth-1], b})
              : ({a[CoefWidth-1], a} + {b[CoefWidth-1], b});
      if (s[CoefWidth] != s[CoefWidth-1])
         return s[CoefWidth] ? {1'b1, {(CoefWidth-1){1'b0}}}
                             : {1'b0, {(CoefWidth-1){1'b1}}};
      return s[CoefWidth-1:0];
   endfunction

endpackage

// ===== rtl/sparse_poly_add_sub.sv =====
// ----------------------------------------------------------------------------
// sparse_poly_add_sub: sparse polynomial adder and subtractor
// Builds a term table from two polynomials and emits the sorted sum or difference.
// ----------------------------------------------------------------------------
// Requests arrive on req_valid/req_stall with a req_type payload; results
// leave on rsp_valid/rsp_stall as rsp_type. A transfer happens when valid is
// high and stall is low. csr_write_enable loads subtract_mode; the user must
// write it only while idle, as the block itself does not enforce this. A load
// appends one term if the table has room. An apply searches the table entry
// by entry for a matching exponent and merges into it, or appends the term if
// none matches. A finish runs a bubble sort over the table, then reads out the
// terms; the pending register holds the term ahead of the one being examined.
// Reset clears the entry count, the overflow flag and the valid flag; the table
// contents need no clearing. While the receiver stalls, the result register
// holds its transfer and emission pauses until it is taken.
// ----------------------------------------------------------------------------
module sparse_poly_add_sub import spas_pkg::*; #(
   parameter int unsigned TABLE_DEPTH = DefTableDepth
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data,
   input  logic    csr_write_enable,
   input  logic    csr_write_data
);

   logic       subtract_mode_ff;
   cmd_type    cmd;
   status_type sts;

   always_ff @(posedge clock) begin
      if (reset) begin
         subtract_mode_ff <= 1'b0;
      end else if (csr_write_enable) begin
         subtract_mode_ff <= csr_write_data;
      end
   end

   spas_controller u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_opcode (req_data.opcode),
      .sts        (sts),
      .cmd        (cmd)
   );

   spas_datapath #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_dp (
      .clock         (clock),
      .reset         (reset),
      .subtract_mode (subtract_mode_ff),
      .req_data      (req_data),
      .cmd           (cmd),
      .sts           (sts),
      .rsp_stall     (rsp_stall),
      .rsp_valid     (rsp_valid),
      .rsp_data      (rsp_data)
   );

endmodule

// ===== rtl/spas_datapath.sv =====
// ----------------------------------------------------------------------------
// spas_datapath: term table and arithmetic
// Holds the term memories, index counter, merge adder and output register.
// ----------------------------------------------------------------------------
module spas_datapath import spas_pkg::*; #(
   parameter int unsigned TABLE_DEPTH = DefTableDepth
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       subtract_mode,
   input  req_type    req_data,
   input  cmd_type    cmd,
   output status_type sts,
   input  logic       rsp_stall,
   output logic       rsp_valid,
   output rsp_type    rsp_data
);

   localparam int unsigned IdxW = $clog2(TABLE_DEPTH);
   localparam int unsigned CntW = $clog2(TABLE_DEPTH + 1);

   logic signed [CoefWidth-1:0] coef_mem [TABLE_DEPTH];
   logic [ExpWidth-1:0]         exp_mem  [TABLE_DEPTH];

   req_type                     req_ff;
   logic [CntW-1:0]             count_ff, count_in;
   logic [CntW-1:0]             idx_ff, idx_in;
   logic                        ovf_ff, ovf_in;
   logic                        swapped_ff, swapped_in;
   logic signed [CoefWidth-1:0] ca_ff, cb_ff;
   logic [ExpWidth-1:0]         ea_ff, eb_ff;
   logic signed [CoefWidth-1:0] pc_ff;
   logic [ExpWidth-1:0]         pe_ff;
   logic                        pend_ff, pend_in;
   logic                        vld_ff, vld_in;
   rsp_type                     out_ff;

   logic [IdxW-1:0]             ia, ib;
   logic [CntW-1:0]             idx_p1;
   logic signed [CoefWidth-1:0] neg_c;

   assign idx_p1 = idx_ff + CntW'(1);
   assign ia     = idx_ff[IdxW-1:0];
   assign ib     = idx_p1[IdxW-1:0];
   assign neg_c  = sat_add('0, req_ff.coefficient, 1'b1);

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         req_ff <= req_data;
      end
      if (cmd.append && count_ff < CntW'(TABLE_DEPTH)) begin
         coef_mem[count_ff[IdxW-1:0]] <= (req_ff.opcode == OP_APPLY && subtract_mode)
                                         ? neg_c : req_ff.coefficient;
         exp_mem[count_ff[IdxW-1:0]]  <= req_ff.exponent;
      end
      if (cmd.update) begin
         coef_mem[ia] <= sat_add(ca_ff, req_ff.coefficient, subtract_mode);
      end
      if (cmd.swap) begin
         coef_mem[ia] <= cb_ff;
         exp_mem[ia]  <= eb_ff;
         coef_mem[ib] <= ca_ff;
         exp_mem[ib]  <= ea_ff;
      end
      if (cmd.read_idx || cmd.read_pair) begin
         ca_ff <= coef_mem[ia];
         ea_ff <= exp_mem[ia];
      end
      if (cmd.read_pair) begin
         cb_ff <= coef_mem[ib];
         eb_ff <= exp_mem[ib];
      end
      if (cmd.hold_load) begin
         pc_ff <= ca_ff;
         pe_ff <= ea_ff;
      end
      if (cmd.send || cmd.send_empty) begin
         out_ff.coefficient_out <= cmd.send_empty ? '0 : pc_ff;
         out_ff.exponent_out    <= cmd.send_empty ? '0 : pe_ff;
         out_ff.last_term       <= cmd.send_empty | cmd.send_last;
         out_ff.empty_result    <= cmd.send_empty;
         out_ff.table_overflow  <= ovf_ff;
      end
   end

   always_comb begin
      count_in = count_ff;
      ovf_in   = ovf_ff;
      if (cmd.append) begin
         if (count_ff < CntW'(TABLE_DEPTH)) begin
            count_in = count_ff + CntW'(1);
         end else begin
            ovf_in = 1'b1;
         end
      end
      if (cmd.count_clear) begin
         count_in = '0;
      end
      idx_in = idx_ff;
      if (cmd.idx_clear) begin
         idx_in = '0;
      end else if (cmd.idx_inc) begin
         idx_in = idx_p1;
      end
      swapped_in = swapped_ff;
      if (cmd.swapped_clr) begin
         swapped_in = 1'b0;
      end else if (cmd.swap) begin
         swapped_in = 1'b1;
      end
      pend_in = pend_ff;
      if (cmd.send) begin
         pend_in = 1'b0;
      end
      if (cmd.hold_load) begin
         pend_in = 1'b1;
      end
      if (cmd.count_clear) begin
         pend_in = 1'b0;
      end
      vld_in = vld_ff;
      if (vld_ff && !rsp_stall) begin
         vld_in = 1'b0;
      end
      if (cmd.send || cmd.send_empty) begin
         vld_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= '0;
         idx_ff     <= '0;
         ovf_ff     <= 1'b0;
         swapped_ff <= 1'b0;
         pend_ff    <= 1'b0;
         vld_ff     <= 1'b0;
      end else begin
         count_ff   <= count_in;
         idx_ff     <= idx_in;
         ovf_ff     <= ovf_in;
         swapped_ff <= swapped_in;
         pend_ff    <= pend_in;
         vld_ff     <= vld_in;
      end
   end

   assign sts.match        = (ea_ff == req_ff.exponent);
   assign sts.idx_end      = (idx_ff >= count_ff);
   assign sts.pair_end     = (idx_p1 >= count_ff);
   assign sts.out_of_order = (ea_ff > eb_ff);
   assign sts.swapped      = swapped_ff;
   assign sts.nonzero      = (ca_ff != '0);
   assign sts.have_pending = pend_ff;
   assign sts.rsp_busy     = vld_ff && rsp_stall;

   assign rsp_valid = vld_ff;
   assign rsp_data  = out_ff;

endmodule

// ===== rtl/spas_controller.sv =====
// ----------------------------------------------------------------------------
// spas_controller: sequencing state machine
// Steps the datapath through load, search, bubble sort and emission of the table.
// ----------------------------------------------------------------------------
module spas_controller import spas_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [1:0] req_opcode,
   input  status_type sts,
   output cmd_type    cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.capture   = 1'b1;
               cmd.idx_clear = 1'b1;
               cmd.swapped_clr = 1'b1;
               case (req_opcode)
                  OP_LOAD:   state_in = ST_UPDATE;
                  OP_APPLY:  state_in = ST_SEARCH;
                  OP_FINISH: state_in = ST_SORT_SCAN;
                  default:   state_in = ST_IDLE;
               endcase
            end
         end
         ST_SEARCH: begin
            if (sts.idx_end) begin
               cmd.append = 1'b1;
               state_in   = ST_IDLE;
            end else begin
               cmd.read_idx = 1'b1;
               state_in     = ST_SEARCH_WAIT;
            end
         end
         ST_SEARCH_WAIT: begin
            if (sts.match) begin
               cmd.update = 1'b1;
               state_in   = ST_IDLE;
            end else begin
               cmd.idx_inc = 1'b1;
               state_in    = ST_SEARCH;
            end
         end
         ST_UPDATE: begin
            cmd.append = 1'b1;
            state_in   = ST_IDLE;
         end
         ST_SORT_SCAN: begin
            if (sts.pair_end || sts.idx_end) begin
               cmd.idx_clear = 1'b1;
               if (sts.swapped) begin
                  cmd.swapped_clr = 1'b1;
               end else begin
                  state_in = ST_EMIT_READ;
               end
            end else begin
               cmd.read_pair = 1'b1;
               state_in      = ST_SORT_WAIT;
            end
         end
         ST_SORT_WAIT: begin
            if (sts.out_of_order) begin
               state_in = ST_SORT_SWAP;
            end else begin
               cmd.idx_inc = 1'b1;
               state_in    = ST_SORT_SCAN;
            end
         end
         ST_SORT_SWAP: begin
            cmd.swap    = 1'b1;
            cmd.idx_inc = 1'b1;
            state_in    = ST_SORT_SCAN;
         end
         ST_EMIT_READ: begin
            if (sts.idx_end) begin
               state_in = ST_EMIT_LAST;
            end else begin
               cmd.read_idx = 1'b1;
               state_in     = ST_EMIT_WAIT;
            end
         end
         ST_EMIT_WAIT: begin
            state_in = ST_EMIT_CHECK;
         end
         ST_EMIT_CHECK: begin
            if (!sts.nonzero) begin
               cmd.idx_inc = 1'b1;
               state_in    = ST_EMIT_READ;
            end else if (!sts.have_pending) begin
               cmd.hold_load = 1'b1;
               cmd.idx_inc   = 1'b1;
               state_in      = ST_EMIT_READ;
            end else if (!sts.rsp_busy) begin
               cmd.send      = 1'b1;
               cmd.hold_load = 1'b1;
               cmd.idx_inc   = 1'b1;
               state_in      = ST_EMIT_READ;
            end
         end
         ST_EMIT_LAST: begin
            if (!sts.rsp_busy) begin
               if (sts.have_pending) begin
                  cmd.send      = 1'b1;
                  cmd.send_last = 1'b1;
               end else begin
                  cmd.send_empty = 1'b1;
               end
               cmd.count_clear = 1'b1;
               state_in        = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule
